### hw/rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle generator package
// Shared widths, codes and payload types of the circle generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

  localparam int RADIUS_WIDTH = 9;
  localparam int COORD_WIDTH  = 10;
  localparam int DEC_WIDTH    = RADIUS_WIDTH + 3;
  localparam int PIX_WIDTH    = COORD_WIDTH + 2;
  localparam int CFG_WIDTH    = COORD_WIDTH;
  localparam int CFG_IDX_W    = 1;

  localparam int CENTER_RESET = 200;
  localparam int D_INC_E      = 3;
  localparam int D_INC_SE     = 5;

  localparam int NUM_POINTS   = 8;
  localparam int PT_IDX_W     = $clog2(NUM_POINTS);

  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [RADIUS_WIDTH-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_WIDTH-1:0] pixel_x;
    logic signed [PIX_WIDTH-1:0] pixel_y;
    logic                        pixel_valid;
    logic                        done_res;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic [RADIUS_WIDTH-1:0] x;
    logic [RADIUS_WIDTH-1:0] y;
    logic                    done;
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/mcg_front.sv
// ----------------------------------------------------------------------------
// Circle generator front end
// Accepts commands, loads or advances the octant walker and queues one job per command.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  mcg_pkg::in_item_t     in_item,
  input  wire logic             q_full,
  output logic                  q_push,
  output mcg_pkg::job_t         q_job
);
  import mcg_pkg::*;

  logic [RADIUS_WIDTH-1:0] oct_x_r, oct_x_nxt;
  logic [RADIUS_WIDTH-1:0] oct_y_r, oct_y_nxt;
  logic [DEC_WIDTH-1:0]    decision_r, decision_nxt;
  logic                    running_r, running_nxt;

  logic                    in_acc;
  logic                    is_start;
  logic                    finished;
  logic [DEC_WIDTH-1:0]    x_twice;
  logic [DEC_WIDTH-1:0]    y_twice;
  logic [DEC_WIDTH-1:0]    d_step;

  assign in_acc   = in_push && !q_full;
  assign is_start = (in_item.func == FUNC_START);
  assign finished = !running_r || (oct_y_r <= oct_x_r);
  assign x_twice  = DEC_WIDTH'(oct_x_r) << 1;
  assign y_twice  = DEC_WIDTH'(oct_y_r) << 1;

  always_comb begin
    if (decision_r[DEC_WIDTH-1]) begin
      d_step = decision_r + x_twice + DEC_WIDTH'(D_INC_E);
    end else begin
      d_step = decision_r + x_twice - y_twice + DEC_WIDTH'(D_INC_SE);
    end
  end

  always_comb begin
    oct_x_nxt    = oct_x_r;
    oct_y_nxt    = oct_y_r;
    decision_nxt = decision_r;
    running_nxt  = running_r;
    q_job        = '0;
    if (in_acc) begin
      if (is_start) begin
        oct_x_nxt    = '0;
        oct_y_nxt    = in_item.radius;
        decision_nxt = DEC_WIDTH'(1) - DEC_WIDTH'(in_item.radius);
        running_nxt  = 1'b1;
        q_job.x      = '0;
        q_job.y      = in_item.radius;
      end else if (finished) begin
        running_nxt  = 1'b0;
        q_job.done   = 1'b1;
      end else begin
        oct_x_nxt    = oct_x_r + RADIUS_WIDTH'(1);
        oct_y_nxt    = decision_r[DEC_WIDTH-1] ? oct_y_r : oct_y_r - RADIUS_WIDTH'(1);
        decision_nxt = d_step;
        q_job.x      = oct_x_nxt;
        q_job.y      = oct_y_nxt;
      end
    end
  end

  assign q_push = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_x_r    <= '0;
      oct_y_r    <= '0;
      decision_r <= '0;
      running_r  <= 1'b0;
    end else begin
      oct_x_r    <= oct_x_nxt;
      oct_y_r    <= oct_y_nxt;
      decision_r <= decision_nxt;
      running_r  <= running_nxt;
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_start) |=> running_r)
    else $error("walker not running after a start");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_job.done) |=> !running_r)
    else $error("walker still running after a done marker");

  a_step_moves_x: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_job.done && !is_start) |=> (oct_x_r == $past(oct_x_r) + RADIUS_WIDTH'(1)))
    else $error("step did not advance x");

endmodule

`default_nettype wire

### hw/rtl/mcg_job_queue.sv
// ----------------------------------------------------------------------------
// Circle generator job queue
// Short first-in first-out queue that decouples the walker from the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_job_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  mcg_pkg::job_t  push_job,
  output logic           full,
  input  wire logic      pop,
  output mcg_pkg::job_t  head_job,
  output logic           empty
);
  import mcg_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into a full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == QCNT_W'(QDEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step with the count");

endmodule

`default_nettype wire

### hw/rtl/mcg_emitter.sv
// ----------------------------------------------------------------------------
// Circle generator emitter
// Expands each queued job into eight mirrored screen points or a done marker.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_emitter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [mcg_pkg::COORD_WIDTH-1:0] center_x,
  input  wire logic [mcg_pkg::COORD_WIDTH-1:0] center_y,
  input  mcg_pkg::job_t                       job,
  input  wire logic                           job_empty,
  output logic                                job_pop,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output mcg_pkg::out_item_t                  out_item
);
  import mcg_pkg::*;

  logic [PT_IDX_W-1:0]  idx_r, idx_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_item_r;
  out_item_t            point;
  logic                 load;
  logic                 job_last;
  logic                 swap;
  logic                 neg_a;
  logic                 neg_b;
  logic [PIX_WIDTH-1:0] a_mag;
  logic [PIX_WIDTH-1:0] b_mag;

  assign load     = !job_empty && (!out_vld_r || out_pop);
  assign job_last = job.done || (idx_r == PT_IDX_W'(NUM_POINTS - 1));
  assign job_pop  = load && job_last;

  always_comb begin
    swap  = 1'b0;
    neg_a = 1'b0;
    neg_b = 1'b0;
    case (idx_r)
      3'd1: begin swap = 1'b1; end
      3'd2: begin swap = 1'b1; neg_b = 1'b1; end
      3'd3: begin neg_b = 1'b1; end
      3'd4: begin neg_a = 1'b1; neg_b = 1'b1; end
      3'd5: begin swap = 1'b1; neg_a = 1'b1; neg_b = 1'b1; end
      3'd6: begin swap = 1'b1; neg_a = 1'b1; end
      3'd7: begin neg_a = 1'b1; end
      default: begin swap = 1'b0; end
    endcase
  end

  assign a_mag = swap ? PIX_WIDTH'(job.y) : PIX_WIDTH'(job.x);
  assign b_mag = swap ? PIX_WIDTH'(job.x) : PIX_WIDTH'(job.y);

  always_comb begin
    point = '0;
    if (job.done) begin
      point.done_res = 1'b1;
      point.last     = 1'b1;
    end else begin
      point.pixel_x     = neg_a ? PIX_WIDTH'(center_x) - a_mag : PIX_WIDTH'(center_x) + a_mag;
      point.pixel_y     = neg_b ? PIX_WIDTH'(center_y) + b_mag : PIX_WIDTH'(center_y) - b_mag;
      point.pixel_valid = 1'b1;
      point.last        = job_last;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    if (load) begin
      idx_nxt     = job_last ? '0 : idx_r + PT_IDX_W'(1);
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!job_empty && job.done) |-> (idx_r == '0))
    else $error("done marker started in the middle of a point group");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.done_res) |-> (out_item_r.last && !out_item_r.pixel_valid))
    else $error("done marker malformed");

  a_idx_resets: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (idx_r == '0))
    else $error("point index not cleared after a job");

endmodule

`default_nettype wire

### hw/rtl/midpoint_circle_generator_top.sv
// ----------------------------------------------------------------------------
// Midpoint circle generator
// Rasterizes circles with the midpoint rule and eight-way symmetry.
// ----------------------------------------------------------------------------
// Commands enter through in_push/in_full with in_item (func, radius); a
// transfer takes place when in_push is high and in_full is low. A start
// command loads the octant walker, a step command advances it by one pixel.
// Each command yields eight screen points, or a single done marker once the
// octant is finished or no circle is active. Results leave through
// out_empty/out_pop with out_item; the oldest result waits on out_item while
// out_empty is low. The center registers are written through cfg_we,
// cfg_index and cfg_data and should change only while the block is idle.
// A command's job passes through the job queue and then the output register;
// the output stage delivers one result per cycle while the receiver pops,
// and the walker runs ahead through the two-entry job queue. When the
// receiver stalls, results hold, the queue fills and in_full rises. Reset
// clears the walker, the queue and the output stage and sets both center
// coordinates to 200.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_generator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  mcg_pkg::in_item_t                   in_item,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output mcg_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_we,
  input  wire logic [mcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcg_pkg::CFG_WIDTH-1:0]  cfg_data
);
  import mcg_pkg::*;

  logic [COORD_WIDTH-1:0] center_x_r;
  logic [COORD_WIDTH-1:0] center_y_r;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  job_t                   q_in_job;
  job_t                   q_head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= COORD_WIDTH'(CENTER_RESET);
      center_y_r <= COORD_WIDTH'(CENTER_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        default: center_x_r <= center_x_r;
      endcase
    end
  end

  mcg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  mcg_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head_job),
    .empty    (q_empty)
  );

  mcg_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .job       (q_head_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign in_full = q_full;

endmodule

`default_nettype wire

### test/circle_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point checker
// Watches the command, result and center register ports of the circle
// generator, predicts the screen points of each accepted command and compares
// every accepted result field by field with the oldest predicted point.
// ----------------------------------------------------------------------------

module circle_point_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  mcg_pkg::in_item_t             in_item,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  mcg_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [mcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcg_pkg::CFG_WIDTH-1:0] cfg_data,
  output int                            expected_count,
  output int                            mismatch_count
);
  import mcg_pkg::*;

  logic [COORD_WIDTH-1:0]     center_col;
  logic [COORD_WIDTH-1:0]     center_row;
  logic [RADIUS_WIDTH-1:0]    walk_x;
  logic [RADIUS_WIDTH-1:0]    walk_y;
  logic signed [DEC_WIDTH-1:0] walk_dec;
  logic                       circle_active;
  out_item_t                  expected_points[$];
  int                         mismatches;

  initial begin
    expected_count = 0;
    mismatch_count = 0;
    mismatches     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic plot_octants();
    int        ax[8];
    int        ay[8];
    int        col;
    int        row;
    out_item_t pt;
    ax = '{int'(walk_x), int'(walk_y), int'(walk_y), int'(walk_x),
           -int'(walk_x), -int'(walk_y), -int'(walk_y), -int'(walk_x)};
    ay = '{int'(walk_y), int'(walk_x), -int'(walk_x), -int'(walk_y),
           -int'(walk_y), -int'(walk_x), int'(walk_x), int'(walk_y)};
    for (int k = 0; k < NUM_POINTS; k++) begin
      col            = int'(center_col) + ax[k];
      row            = int'(center_row) - ay[k];
      pt.pixel_x     = col[PIX_WIDTH-1:0];
      pt.pixel_y     = row[PIX_WIDTH-1:0];
      pt.pixel_valid = 1'b1;
      pt.done_res    = 1'b0;
      pt.last        = (k == NUM_POINTS - 1);
      expected_points.push_back(pt);
    end
  endtask

  task automatic predict_points(input in_item_t cmd);
    int        d;
    int        x;
    int        y;
    out_item_t marker;
    if (cmd.func == FUNC_START) begin
      walk_x        = '0;
      walk_y        = cmd.radius;
      d             = 1 - int'(cmd.radius);
      walk_dec      = d[DEC_WIDTH-1:0];
      circle_active = 1'b1;
      plot_octants();
    end else if (!circle_active || walk_y <= walk_x) begin
      circle_active      = 1'b0;
      marker.pixel_x     = '0;
      marker.pixel_y     = '0;
      marker.pixel_valid = 1'b0;
      marker.done_res    = 1'b1;
      marker.last        = 1'b1;
      expected_points.push_back(marker);
    end else begin
      d = int'(walk_dec);
      x = int'(walk_x);
      y = int'(walk_y);
      if (d < 0) begin
        d = d + 2 * x + D_INC_E;
        x = x + 1;
      end else begin
        d = d + 2 * (x - y) + D_INC_SE;
        x = x + 1;
        y = y - 1;
      end
      walk_dec = d[DEC_WIDTH-1:0];
      walk_x   = x[RADIUS_WIDTH-1:0];
      walk_y   = y[RADIUS_WIDTH-1:0];
      plot_octants();
    end
  endtask

  task automatic check_point(input out_item_t got);
    out_item_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %p", got));
      return;
    end
    want = expected_points.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      report_mismatch($sformatf("pixel_x got %0d expected %0d", got.pixel_x, want.pixel_x));
    end
    if (got.pixel_y !== want.pixel_y) begin
      report_mismatch($sformatf("pixel_y got %0d expected %0d", got.pixel_y, want.pixel_y));
    end
    if (got.pixel_valid !== want.pixel_valid) begin
      report_mismatch($sformatf("pixel_valid got %b expected %b",
                                got.pixel_valid, want.pixel_valid));
    end
    if (got.done_res !== want.done_res) begin
      report_mismatch($sformatf("done_res got %b expected %b", got.done_res, want.done_res));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last got %b expected %b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      center_col    = COORD_WIDTH'(CENTER_RESET);
      center_row    = COORD_WIDTH'(CENTER_RESET);
      walk_x        = '0;
      walk_y        = '0;
      walk_dec      = '0;
      circle_active = 1'b0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: center_col = cfg_data;
          CFG_CENTER_Y: center_row = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        check_point(out_item);
      end
      if (in_push && !in_full) begin
        predict_points(in_item);
      end
    end
    expected_count <= expected_points.size();
    mismatch_count <= mismatches;
  end

endmodule

### test/tb_midpoint_circle_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator testbench
// Drives start and step commands through directed circles and random circle
// sequences under several center settings and idle patterns, including a long
// receiver hold-off, while a checker predicts and compares every point.
// ----------------------------------------------------------------------------

module tb_midpoint_circle_generator_top;
  import mcg_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  in_item_t             in_item   = '0;
  logic                 out_pop   = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;
  logic                 in_full;
  logic                 out_empty;
  out_item_t            out_item;
  int                   expected_count;
  int                   mismatch_count;
  int                   send_idle_pct = 0;
  int                   pop_stall_pct = 0;
  int                   hold_len      = 0;
  int                   quiet_cycles  = 0;

  midpoint_circle_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  circle_point_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .expected_count (expected_count),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_pop <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic send_cmd(input logic func, input logic [RADIUS_WIDTH-1:0] radius);
    in_item_t cmd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    cmd.func   = func;
    cmd.radius = radius;
    in_item <= cmd;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (expected_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_centers(input logic [CFG_WIDTH-1:0] col,
                             input logic [CFG_WIDTH-1:0] row);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER_X;
    cfg_data  <= col;
    @(posedge clk);
    cfg_index <= CFG_CENTER_Y;
    cfg_data  <= row;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int radius;
    int steps;
    sent = 0;
    send_cmd(FUNC_START, RADIUS_WIDTH'(511));
    send_cmd(FUNC_STEP, RADIUS_WIDTH'($urandom_range(0, 511)));
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_cmd(FUNC_STEP, RADIUS_WIDTH'($urandom_range(0, 511)));
        sent++;
      end else begin
        if ($urandom_range(99) < 85) begin
          radius = $urandom_range(0, 24);
          steps  = radius * 3 / 4 + 3;
        end else begin
          radius = $urandom_range(25, 511);
          steps  = $urandom_range(1, 10);
        end
        if ($urandom_range(99) < 15) begin
          steps = $urandom_range(0, steps);
        end
        send_cmd(FUNC_START, RADIUS_WIDTH'(radius));
        for (int i = 0; i < steps; i++) begin
          send_cmd(FUNC_STEP, RADIUS_WIDTH'($urandom_range(0, 511)));
        end
        sent += steps + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(FUNC_STEP, '1);
    send_cmd(FUNC_START, '0);
    send_cmd(FUNC_STEP, '0);
    send_cmd(FUNC_STEP, '0);
    send_cmd(FUNC_START, RADIUS_WIDTH'(511));
    send_cmd(FUNC_STEP, '0);
    send_cmd(FUNC_STEP, '1);
    send_cmd(FUNC_START, RADIUS_WIDTH'(1));
    send_cmd(FUNC_STEP, '0);
    send_cmd(FUNC_STEP, '0);
    send_cmd(FUNC_START, RADIUS_WIDTH'(3));
    for (int i = 0; i < 4; i++) begin
      send_cmd(FUNC_STEP, '0);
    end
    send_cmd(FUNC_START, RADIUS_WIDTH'(4));
    send_cmd(FUNC_START, RADIUS_WIDTH'(2));
    for (int i = 0; i < 3; i++) begin
      send_cmd(FUNC_STEP, '0);
    end
    drain();

    set_centers('0, '0);
    run_random(34);
    drain();

    set_centers('1, '1);
    send_idle_pct = 70;
    run_random(34);
    drain();

    set_centers('0, '1);
    send_idle_pct = 0;
    pop_stall_pct = 70;
    run_random(34);
    drain();

    set_centers('1, '0);
    send_idle_pct = 38;
    pop_stall_pct = 38;
    run_random(34);
    drain();

    set_centers(CFG_WIDTH'($urandom_range(0, 1023)), CFG_WIDTH'($urandom_range(0, 1023)));
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_len      = 300;
    run_random(30);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mcg_pkg.sv
hw/rtl/mcg_front.sv
hw/rtl/mcg_job_queue.sv
hw/rtl/mcg_emitter.sv
hw/rtl/midpoint_circle_generator_top.sv
test/circle_point_checker.sv
test/tb_midpoint_circle_generator_top.sv
